[rtl/ssrl_pkg.sv]
`default_nettype none
package ssrl_pkg;

  // Command codes on in_cmd
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Status codes on out_status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_ZERO    = 2'd2;
  localparam logic [1:0] ST_NOMATCH = 2'd3;

  typedef struct packed {
    logic [63:0] start;
    logic [63:0] size;
    logic [31:0] tag;
  } ssrl_entry_t;

  // Match result travelling down the chain towards the head cell
  typedef struct packed {
    logic        hit;
    ssrl_entry_t ent;
  } ssrl_carry_t;

  // Insert control broadcast to every cell
  typedef struct packed {
    logic        ins_en;
    ssrl_entry_t ent;
  } ssrl_ctrl_t;

endpackage
`default_nettype wire

[rtl/ssrl_cell.sv]
`default_nettype none
module ssrl_cell (
  input  wire                  clk,
  input  ssrl_pkg::ssrl_ctrl_t ctrl_i,
  input  wire                  valid_i,
  input  wire                  prev_ge_i,
  input  ssrl_pkg::ssrl_entry_t prev_ent_i,
  output logic                 ge_o,
  output ssrl_pkg::ssrl_entry_t ent_o,
  input  wire  [63:0]          query_i,
  input  wire  [63:0]          base_i,
  input  ssrl_pkg::ssrl_carry_t carry_i,
  output ssrl_pkg::ssrl_carry_t carry_o
);
  import ssrl_pkg::*;

  ssrl_entry_t ent_r;
  ssrl_entry_t ent_nxt;
  logic        valid_r;
  logic        le_r;
  logic        gt_r;
  logic [63:0] diff_r;
  logic        hit_r;
  ssrl_carry_t carry_r;

  // Entries at or above the new start stay in place
  assign ge_o  = valid_i && (ent_r.start >= ctrl_i.ent.start);
  assign ent_o = ent_r;

  // Hold, take the new entry, or take the neighbour's entry on insert
  always_comb begin
    ent_nxt = ent_r;
    if (ctrl_i.ins_en && !ge_o) begin
      ent_nxt = prev_ge_i ? ctrl_i.ent : prev_ent_i;
    end
  end

  // First compare stage: bounds and offset into the entry
  always_ff @(posedge clk) begin
    ent_r   <= ent_nxt;
    valid_r <= valid_i;
    le_r    <= ent_r.start <= query_i;
    gt_r    <= ent_r.start > base_i;
    diff_r  <= query_i - ent_r.start;
  end

  // Second compare stage, then pass the nearest hit towards the head
  always_ff @(posedge clk) begin
    hit_r <= valid_r && le_r && gt_r && (diff_r <= ent_r.size);
    if (hit_r) begin
      carry_r <= '{hit: 1'b1, ent: ent_r};
    end else begin
      carry_r <= carry_i;
    end
  end

  assign carry_o = carry_r;

endmodule
`default_nettype wire

[rtl/sorted_symbol_range_lookup_top.sv]
`default_nettype none
// Sorted symbol range table. Entries are held one per cell in a chain, in
// descending start order; insert, clear and any other command complete in the
// cycle they are accepted and their result strobes on the next cycle. A lookup
// compares every cell in two pipelined steps and then passes the nearest hit
// along the chain one cell per cycle, so busy stays high and the result strobes
// only once the scan has passed along the whole length of the chain.
// Results are shown for one cycle on out_strobe and cannot be held off.
// cfg_data is written to the base address whenever cfg_we is high.
module sorted_symbol_range_lookup_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  in_cmd,
  input  wire  [63:0] in_addr,
  input  wire  [63:0] in_length,
  input  wire  [31:0] in_tag,
  output logic        out_strobe,
  output logic        out_found,
  output logic [1:0]  out_status,
  output logic [63:0] out_sym_addr,
  output logic [63:0] out_sym_size,
  output logic [31:0] out_sym_tag,
  output logic [6:0]  out_entry_count,
  input  wire         cfg_we,
  input  wire  [63:0] cfg_data
);
  import ssrl_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_HIT  = 2'd2;
  localparam logic [1:0] S_SCAN = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic [63:0]   base_r;
  logic [63:0]   query_r;

  logic          accept;
  logic          ins_ok;
  logic [1:0]    ins_status;
  ssrl_ctrl_t    ctrl;

  logic          ge      [TABLE_DEPTH];
  ssrl_entry_t   ent     [TABLE_DEPTH];
  ssrl_carry_t   carry   [TABLE_DEPTH];
  logic [CW+6:0] count_ext;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Insert goes ahead only with a non-zero start and room left
  assign ins_ok = (in_addr != 64'd0) && (count_r < CW'(TABLE_DEPTH));
  always_comb begin
    if (in_addr == 64'd0) begin
      ins_status = ST_ZERO;
    end else if (!ins_ok) begin
      ins_status = ST_FULL;
    end else begin
      ins_status = ST_OK;
    end
  end

  assign ctrl.ins_en    = accept && (in_cmd == CMD_INSERT) && ins_ok;
  assign ctrl.ent.start = in_addr;
  assign ctrl.ent.size  = in_length;
  assign ctrl.ent.tag   = in_tag;

  // Chain of entry cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic        prev_ge;
    ssrl_entry_t prev_ent;
    ssrl_carry_t next_carry;

    if (i == 0) begin : g_head
      assign prev_ge  = 1'b1;
      assign prev_ent = ctrl.ent;
    end else begin : g_body
      assign prev_ge  = ge[i-1];
      assign prev_ent = ent[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign next_carry = '0;
    end else begin : g_link
      assign next_carry = carry[i+1];
    end

    ssrl_cell u_cell (
      .clk        (clk),
      .ctrl_i     (ctrl),
      .valid_i    (count_r > CW'(i)),
      .prev_ge_i  (prev_ge),
      .prev_ent_i (prev_ent),
      .ge_o       (ge[i]),
      .ent_o      (ent[i]),
      .query_i    (query_r),
      .base_i     (base_r),
      .carry_i    (next_carry),
      .carry_o    (carry[i])
    );
  end

  // Sequencer: lookups walk compare, hit and scan phases
  always_comb begin
    state_nxt = state_r;
    scan_nxt  = scan_r;
    count_nxt = count_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_INSERT: begin
              if (ins_ok) begin
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_LOOKUP: state_nxt = S_CMP;
            CMD_CLEAR:  count_nxt = '0;
            default:    count_nxt = count_r;
          endcase
        end
      end
      S_CMP: state_nxt = S_HIT;
      S_HIT: begin
        state_nxt = S_SCAN;
        scan_nxt  = '0;
      end
      S_SCAN: begin
        if (scan_r == CW'(TABLE_DEPTH)) begin
          state_nxt = S_IDLE;
        end else begin
          scan_nxt = scan_r + CW'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      scan_r  <= '0;
      base_r  <= 64'd0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      scan_r  <= scan_nxt;
      if (cfg_we) begin
        base_r <= cfg_data;
      end
    end
  end

  // Latch the query address for the compare pipeline
  always_ff @(posedge clk) begin
    if (accept) begin
      query_r <= in_addr;
    end
  end

  assign count_ext = (CW+7)'(count_nxt);

  // Result register: one strobe per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= (accept && (in_cmd != CMD_LOOKUP)) ||
                    ((state_r == S_SCAN) && (scan_r == CW'(TABLE_DEPTH)));
    end
  end

  always_ff @(posedge clk) begin
    out_entry_count <= count_ext[6:0];
    if (state_r == S_SCAN) begin
      out_found    <= carry[0].hit;
      out_status   <= carry[0].hit ? ST_OK : ST_NOMATCH;
      out_sym_addr <= carry[0].ent.start;
      out_sym_size <= carry[0].ent.size;
      out_sym_tag  <= carry[0].ent.tag;
    end else begin
      out_found    <= 1'b0;
      out_status   <= (in_cmd == CMD_INSERT) ? ins_status : ST_OK;
      out_sym_addr <= 64'd0;
      out_sym_size <= 64'd0;
      out_sym_tag  <= 32'd0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_cmd == CMD_LOOKUP) |=> busy && !out_strobe)
    else $error("lookup did not hold busy");

  a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && (scan_r == CW'(TABLE_DEPTH)) |=> out_strobe && !busy)
    else $error("lookup result not delivered at end of scan");

  a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_found |-> (out_sym_addr != 64'd0) && (out_status == ST_OK))
    else $error("match reported with zero start");

endmodule
`default_nettype wire
